// ----- hdl/trrc_pkg.sv -----
`default_nettype none
package trrc_pkg;

  localparam int SLOTS_DEF        = 8;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam logic [31:0] TTL_A_RESET = 32'd40000;
  localparam logic [31:0] TTL_B_RESET = 32'd120000;

  localparam int KEY_BITS  = 64;
  localparam int TIME_BITS = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_INVAL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PROV_NONE = 2'd0,
    PROV_A    = 2'd1,
    PROV_B    = 2'd2
  } prov_t;

  typedef enum logic {
    CFG_TTL_A = 1'b0,
    CFG_TTL_B = 1'b1
  } cfg_idx_t;

  // Request token that walks down the row of slot cells.
  typedef struct packed {
    logic                 vld;
    logic [1:0]           op;
    logic [1:0]           prov;
    logic [KEY_BITS-1:0]  key;
    logic                 pref;
    logic                 ok;
    logic                 bypass;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] expiry;
    logic                 hit;
  } trrc_tok_t;

endpackage
`default_nettype wire

// ----- hdl/trrc_cell.sv -----
`default_nettype none
module trrc_cell #(
  parameter int SLOTS        = trrc_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = trrc_pkg::PAYLOAD_BITS_DEF,
  parameter int IDX          = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire trrc_pkg::trrc_tok_t         tok_in,
  input  wire logic [PAYLOAD_BITS-1:0]     data_in,
  input  wire logic [$clog2(SLOTS)-1:0]    tgt_in,
  output trrc_pkg::trrc_tok_t              tok_out,
  output logic [PAYLOAD_BITS-1:0]          data_out,
  output logic [$clog2(SLOTS)-1:0]         tgt_out
);
  import trrc_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic                    valid_r;
  logic [1:0]              prov_r;
  logic [KEY_BITS-1:0]     key_r;
  logic                    pref_r;
  logic [TIME_BITS-1:0]    expiry_r;
  logic [PAYLOAD_BITS-1:0] payload_r;

  trrc_tok_t               tok_r, tok_nxt;
  logic [PAYLOAD_BITS-1:0] data_r, data_nxt;
  logic [IW-1:0]           tgt_r;

  logic live, match, do_ins, do_inval;

  always_comb begin
    live     = valid_r && (tok_in.now < expiry_r);
    match    = tok_in.vld && (tok_in.op == OP_LOOKUP) && !tok_in.bypass && !tok_in.hit &&
               live && (prov_r == tok_in.prov) && (key_r == tok_in.key) &&
               (pref_r == tok_in.pref);
    do_ins   = tok_in.vld && (tok_in.op == OP_INSERT) && !tok_in.bypass && tok_in.ok &&
               (tgt_in == IW'(IDX));
    do_inval = tok_in.vld && (tok_in.op == OP_INVAL) && (prov_r == tok_in.prov);
    tok_nxt     = tok_in;
    tok_nxt.hit = tok_in.hit | match;
    data_nxt    = match ? payload_r : data_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      prov_r    <= 2'd0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r  <= tok_nxt;
      data_r <= data_nxt;
      tgt_r  <= tgt_in;
      if (do_ins) begin
        valid_r   <= 1'b1;
        prov_r    <= tok_in.prov;
        key_r     <= tok_in.key;
        pref_r    <= tok_in.pref;
        expiry_r  <= tok_in.expiry;
        payload_r <= data_in;
      end else if (do_inval) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign tok_out  = tok_r;
  assign data_out = data_r;
  assign tgt_out  = tgt_r;

endmodule
`default_nettype wire

// ----- hdl/ttl_expiring_round_robin_cache_core.sv -----
// Fully associative TTL cache, one slot per cell in a row of SLOTS cells.
// Input channel (in_valid/in_ready) takes one request item: lookup, insert
// or invalidate-by-provider. Output channel (out_valid/out_ready) returns
// exactly one result item per request: hit and cached_payload (zero unless
// a lookup hit a live entry).
// Each request walks the row one cell per cycle while the row is not held;
// every cell applies it to its own slot, and the result is registered in the
// output register once it leaves the last cell. One request is in the row at
// a time; a new request is taken only once the last one has left the row.
// in_ready rises again as soon as the request leaves the row, even while
// its result waits.
// If the receiver stalls with a result pending, the row holds once the request
// reaches the last cell, until the output register frees up; nothing is dropped.
// The lifetime registers are written through cfg_we/cfg_index/cfg_wdata while
// the block is idle, a rule for the user that the block does not enforce.
// Synchronous reset (rst_n low) clears every slot valid bit, the replacement
// pointer and both channels, and restores the lifetimes to 40000 and 120000 ms.
`default_nettype none
module ttl_expiring_round_robin_cache_core #(
  parameter int SLOTS        = trrc_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = trrc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [1:0]  in_provider,
  input  wire logic [63:0] in_key_tag,
  input  wire logic        in_prefer_schedule,
  input  wire logic [63:0] in_payload,
  input  wire logic        in_payload_ok,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [63:0]      out_cached_payload,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import trrc_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic [TIME_BITS-1:0]    ttl_a_r, ttl_b_r;
  logic [IW-1:0]           ptr_r, ptr_nxt;
  logic                    busy_r;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [PAYLOAD_BITS-1:0] out_data_r;

  trrc_tok_t               tok [SLOTS+1];
  logic [PAYLOAD_BITS-1:0] data [SLOTS+1];
  logic [IW-1:0]           tgt [SLOTS+1];
  logic [SLOTS-1:0]        vld_vec;

  trrc_tok_t               tok_head;
  logic [PAYLOAD_BITS-1:0] data_head;
  logic [IW-1:0]           tgt_head;

  logic                 accept, adv, last_vld, ins_taken;
  logic [TIME_BITS-1:0] ttl;

  assign accept   = in_valid && in_ready;
  assign last_vld = tok[SLOTS].vld;
  // Hold the row while its finished result cannot enter the output register.
  assign adv      = !(last_vld && out_valid_r && !out_ready);
  assign in_ready = !busy_r;

  always_comb begin
    case (in_provider)
      PROV_A:  ttl = ttl_a_r;
      PROV_B:  ttl = ttl_b_r;
      default: ttl = '0;
    endcase
    tok_head.vld    = accept;
    tok_head.op     = in_operation;
    tok_head.prov   = in_provider;
    tok_head.key    = in_key_tag;
    tok_head.pref   = in_prefer_schedule;
    tok_head.ok     = in_payload_ok;
    tok_head.bypass = (in_provider == PROV_NONE) || (ttl == '0);
    tok_head.now    = in_now_ms;
    tok_head.expiry = in_now_ms + ttl;
    tok_head.hit    = 1'b0;
    data_head       = (in_operation == OP_INSERT) ? in_payload[PAYLOAD_BITS-1:0] : '0;
    tgt_head        = ptr_r;
    ins_taken       = accept && (in_operation == OP_INSERT) && !tok_head.bypass &&
                      in_payload_ok;
    ptr_nxt         = (ptr_r == IW'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;
  end

  assign tok[0]  = tok_head;
  assign data[0] = data_head;
  assign tgt[0]  = tgt_head;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    trrc_cell #(
      .SLOTS        (SLOTS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX          (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .tok_in   (tok[g]),
      .data_in  (data[g]),
      .tgt_in   (tgt[g]),
      .tok_out  (tok[g+1]),
      .data_out (data[g+1]),
      .tgt_out  (tgt[g+1])
    );
    assign vld_vec[g] = tok[g+1].vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_a_r     <= TTL_A_RESET;
      ttl_b_r     <= TTL_B_RESET;
      ptr_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TTL_A: ttl_a_r <= cfg_wdata;
          CFG_TTL_B: ttl_b_r <= cfg_wdata;
          default:   ttl_a_r <= ttl_a_r;
        endcase
      end
      if (ins_taken) begin
        ptr_r <= ptr_nxt;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (last_vld && adv) begin
        busy_r <= 1'b0;
      end
      if (last_vld && adv) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= tok[SLOTS].hit;
        out_data_r  <= tok[SLOTS].hit ? data[SLOTS] : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_cached_payload = 64'(out_data_r);

  a_one_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= 1)
    else $error("more than one item in the cell row");

  a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (vld_vec == '0))
    else $error("item in cell row while block reports idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && tok[1].vld)
    else $error("accepted item did not enter the row");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= IW'(SLOTS - 1))
    else $error("replacement pointer out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (last_vld && out_valid_r && !out_ready) |=> last_vld && $stable(data[SLOTS]))
    else $error("row moved while result was stalled");

endmodule
`default_nettype wire

// ----- dv/ttl_expiring_round_robin_cache_core_tb.sv -----
`timescale 1ns / 100ps

import trrc_pkg::*;

localparam int          N_SLOTS      = SLOTS_DEF;
localparam logic [1:0]  OP_NOP       = 2'd3;
localparam logic [1:0]  PROV_UNKNOWN = 2'd3;

typedef struct packed {
  logic [1:0]  op;
  logic [1:0]  prov;
  logic [63:0] key;
  logic        pref;
  logic [63:0] data;
  logic        ok;
  logic [31:0] now;
} cache_req_t;

typedef struct packed {
  logic        hit;
  logic [63:0] data;
} lookup_res_t;

class cache_scoreboard;
  logic [31:0]  ttl_a;
  logic [31:0]  ttl_b;
  bit           slot_live [N_SLOTS];
  logic [1:0]   slot_prov [N_SLOTS];
  logic [63:0]  slot_key  [N_SLOTS];
  logic         slot_pref [N_SLOTS];
  logic [31:0]  slot_exp  [N_SLOTS];
  logic [63:0]  slot_data [N_SLOTS];
  int           victim;
  lookup_res_t  expected_q[$];

  function new();
    ttl_a  = TTL_A_RESET;
    ttl_b  = TTL_B_RESET;
    victim = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_prov[i] = PROV_NONE;
    end
  endfunction

  function void set_lifetime(cfg_idx_t idx, logic [31:0] value);
    if (idx == CFG_TTL_A) ttl_a = value;
    else ttl_b = value;
  endfunction

  function logic [31:0] lifetime(logic [1:0] prov);
    case (prov)
      PROV_A:  return ttl_a;
      PROV_B:  return ttl_b;
      default: return 32'd0;
    endcase
  endfunction

  function void note_request(cache_req_t r);
    lookup_res_t res;
    logic [31:0] life;
    bit          bypass;
    res    = '0;
    life   = lifetime(r.prov);
    bypass = (r.prov == PROV_NONE) || (life == 32'd0);
    case (r.op)
      OP_LOOKUP: begin
        // lowest live matching slot wins; expired once now reaches expiry
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!bypass && !res.hit && slot_live[i] && r.now < slot_exp[i] &&
              slot_prov[i] == r.prov && slot_key[i] == r.key && slot_pref[i] == r.pref) begin
            res.hit  = 1'b1;
            res.data = slot_data[i];
          end
        end
      end
      OP_INSERT: begin
        if (!bypass && r.ok) begin
          slot_live[victim] = 1'b1;
          slot_prov[victim] = r.prov;
          slot_key[victim]  = r.key;
          slot_pref[victim] = r.pref;
          slot_data[victim] = r.data;
          slot_exp[victim]  = r.now + life;
          victim = (victim == N_SLOTS - 1) ? 0 : victim + 1;
        end
      end
      OP_INVAL: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_prov[i] == r.prov) slot_live[i] = 1'b0;
        end
      end
      default: ;
    endcase
    expected_q.push_back(res);
  endfunction

  function bit check_result(logic hit, logic [63:0] data, output string msg);
    lookup_res_t want;
    if (expected_q.size() == 0) begin
      msg = $sformatf("unexpected item hit=%0b payload=%h", hit, data);
      return 1'b0;
    end
    want = expected_q.pop_front();
    msg  = "";
    if (hit !== want.hit)
      msg = $sformatf("hit %0b, want %0b; ", hit, want.hit);
    if (data !== want.data)
      msg = {msg, $sformatf("payload %h, want %h", data, want.data)};
    return (msg == "");
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module ttl_expiring_round_robin_cache_core_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = N_SLOTS + 4;
  localparam int NUM_KEYS    = 6;
  localparam int HOLD_CYCLES = 400;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation       = OP_LOOKUP;
  logic [1:0]  in_provider        = PROV_NONE;
  logic [63:0] in_key_tag         = '0;
  logic        in_prefer_schedule = 1'b0;
  logic [63:0] in_payload         = '0;
  logic        in_payload_ok      = 1'b0;
  logic [31:0] in_now_ms          = '0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic        out_hit;
  logic [63:0] out_cached_payload;
  logic        cfg_we             = 1'b0;
  cfg_idx_t    cfg_index          = CFG_TTL_A;
  logic [31:0] cfg_wdata          = '0;

  cache_scoreboard sb;
  int          error_count    = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          pressure_req   = 0;
  int          pressure_seen  = 0;
  int          hold_left      = 0;
  int          step_max       = 3000;
  logic [31:0] clock_ms       = '0;
  logic [63:0] key_pool [NUM_KEYS];

  ttl_expiring_round_robin_cache_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_provider        (in_provider),
    .in_key_tag         (in_key_tag),
    .in_prefer_schedule (in_prefer_schedule),
    .in_payload         (in_payload),
    .in_payload_ok      (in_payload_ok),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_cached_payload (out_cached_payload),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Result side: check accepted items, then pick next ready value.
  always @(posedge clk) begin : result_side
    string msg;
    if (rst_n && out_valid && out_ready) begin
      if (!sb.check_result(out_hit, out_cached_payload, msg)) report_mismatch(msg);
    end
    if (pressure_req != pressure_seen) begin
      pressure_seen = pressure_req;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic cache_req_t make_request(logic [1:0] op, logic [1:0] prov,
                                              logic [63:0] key, logic pref,
                                              logic [63:0] data, logic ok,
                                              logic [31:0] now);
    cache_req_t r;
    r.op   = op;
    r.prov = prov;
    r.key  = key;
    r.pref = pref;
    r.data = data;
    r.ok   = ok;
    r.now  = now;
    return r;
  endfunction

  function automatic cache_req_t random_request();
    cache_req_t r;
    int         pick;
    pick = $urandom_range(99);
    r.op = (pick < 50) ? OP_LOOKUP : (pick < 85) ? OP_INSERT : (pick < 96) ? OP_INVAL : OP_NOP;
    pick   = $urandom_range(99);
    r.prov = (pick < 42) ? PROV_A : (pick < 84) ? PROV_B : (pick < 92) ? PROV_NONE : PROV_UNKNOWN;
    r.key  = ($urandom_range(99) < 90) ? key_pool[$urandom_range(NUM_KEYS - 1)]
                                       : {$urandom, $urandom};
    r.pref = $urandom_range(1);
    r.data = {$urandom, $urandom};
    r.ok   = ($urandom_range(99) < 85);
    // mostly creep forward so entries live a while, sometimes jump anywhere
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(step_max);
    r.now = clock_ms;
    return r;
  endfunction

  task automatic send_item(input cache_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= r.op;
    in_provider        <= r.prov;
    in_key_tag         <= r.key;
    in_prefer_schedule <= r.pref;
    in_payload         <= r.data;
    in_payload_ok      <= r.ok;
    in_now_ms          <= r.now;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  // Drop valid, wait for every result, then let the row empty out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_lifetimes(input logic [31:0] a, input logic [31:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TTL_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_TTL_B;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_lifetime(CFG_TTL_A, a);
    sb.set_lifetime(CFG_TTL_B, b);
  endtask

  task automatic run_phase(input bit do_write, input logic [31:0] a, input logic [31:0] b,
                           input int idle_pct, input int stall_pct, input int step,
                           input int count, input bit pressure);
    drain();
    if (do_write) write_lifetimes(a, b);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    step_max       = step;
    for (int n = 0; n < count; n++) begin
      if (pressure && n == 50) pressure_req++;
      send_item(random_request());
    end
  endtask

  localparam logic [63:0] K1 = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] K2 = 64'hFFFF_FFFF_FFFF_FFFF;

  initial begin
    sb = new();
    for (int i = 0; i < NUM_KEYS; i++) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty cache, then expiry boundary and preference and provider mismatches
    send_item(make_request(OP_LOOKUP, PROV_A, K1, 1'b0, '0, 1'b1, 32'd0));
    send_item(make_request(OP_INSERT, PROV_A, K1, 1'b0, K2, 1'b1, 32'd0));
    send_item(make_request(OP_LOOKUP, PROV_A, K1, 1'b0, '0, 1'b0, 32'd39999));
    send_item(make_request(OP_LOOKUP, PROV_A, K1, 1'b0, '0, 1'b0, 32'd40000));
    send_item(make_request(OP_LOOKUP, PROV_A, K1, 1'b1, '0, 1'b0, 32'd100));
    send_item(make_request(OP_LOOKUP, PROV_B, K1, 1'b0, '0, 1'b0, 32'd100));
    // failed payload, bypassed providers, unused opcode
    send_item(make_request(OP_INSERT, PROV_A, K2, 1'b1, '0, 1'b0, 32'd100));
    send_item(make_request(OP_INSERT, PROV_NONE, '0, 1'b0, 64'd5, 1'b1, 32'd0));
    send_item(make_request(OP_INSERT, PROV_UNKNOWN, '0, 1'b0, 64'd5, 1'b1, 32'd0));
    send_item(make_request(OP_NOP, PROV_A, K1, 1'b0, K2, 1'b1, 32'd100));
    // expiry wraps past 2^32
    send_item(make_request(OP_INSERT, PROV_B, K2, 1'b1, 64'hA5A5_5A5A_C3C3_3C3C, 1'b1,
                           32'hFFFF_FFF0));
    send_item(make_request(OP_LOOKUP, PROV_B, K2, 1'b1, '0, 1'b0, 32'hFFFF_FFF5));
    send_item(make_request(OP_LOOKUP, PROV_B, K2, 1'b1, '0, 1'b0, 32'd5));
    // duplicate key: lowest slot wins
    send_item(make_request(OP_INSERT, PROV_A, K1, 1'b0, 64'h8000_0000_0000_0001, 1'b1,
                           32'd10));
    send_item(make_request(OP_LOOKUP, PROV_A, K1, 1'b0, '0, 1'b0, 32'd20));
    send_item(make_request(OP_INVAL, PROV_A, '0, 1'b0, '0, 1'b0, 32'd20));
    send_item(make_request(OP_LOOKUP, PROV_A, K1, 1'b0, '0, 1'b0, 32'd20));
    send_item(make_request(OP_LOOKUP, PROV_B, K2, 1'b1, '0, 1'b0, 32'd6));
    send_item(make_request(OP_INVAL, PROV_NONE, '0, 1'b0, '0, 1'b0, 32'd6));
    // wrap the replacement pointer round to slot 0; the live provider B entry stays
    for (int i = 0; i < 6; i++)
      send_item(make_request(OP_INSERT, PROV_B, 64'(i), 1'b0, 64'(i + 100), 1'b1, 32'd1000));
    send_item(make_request(OP_LOOKUP, PROV_B, K2, 1'b1, '0, 1'b0, 32'd1001));

    run_phase(1'b0, '0, '0, 0, 0, 3000, 250, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, 32'd0, 54, 0, 3000, 250, 1'b0);
    run_phase(1'b1, 32'd0, 32'hFFFF_FFFF, 0, 54, 3000, 250, 1'b0);
    run_phase(1'b1, 32'd1, 32'd1, 38, 38, 1, 250, 1'b0);
    run_phase(1'b1, 32'($urandom_range(200000, 1)), 32'($urandom_range(200000, 1)),
              38, 38, 3000, 250, 1'b1);
    run_phase(1'b1, 32'd5000, 32'd70000, 0, 0, 2000, 250, 1'b0);

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
